[hdl/ocl_pkg.sv]
`default_nettype none

package ocl_pkg;

  // command codes
  localparam logic [2:0] CMD_FRONT  = 3'd0;
  localparam logic [2:0] CMD_MIDDLE = 3'd1;
  localparam logic [2:0] CMD_BACK   = 3'd2;
  localparam logic [2:0] CMD_AFTER  = 3'd3;
  localparam logic [2:0] CMD_REMOVE = 3'd4;
  localparam logic [2:0] CMD_READ   = 3'd5;

  // status codes
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_FULL    = 2'd1;
  localparam logic [1:0] STAT_EMPTY   = 2'd2;
  localparam logic [1:0] STAT_MISSING = 2'd3;

  // capacity limit after reset
  localparam logic [5:0] CAP_LIMIT_RESET = 6'd20;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [31:0] key;
    logic        tag;
    logic [31:0] target_key;
    logic [4:0]  position;
  } ocl_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  entry_count;
    logic [4:0]  where;
    logic [31:0] read_key;
    logic        read_tag;
  } ocl_out_t;

  // entry store access strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ocl_mem_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_RM_RD,
    S_RM_WR,
    S_RD_WAIT,
    S_DONE
  } ocl_state_t;

endpackage

`default_nettype wire

[hdl/ocl_store.sv]
`default_nettype none

module ocl_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5,
  parameter int DW    = 33
) (
  input  wire                        clk,
  input  wire ocl_pkg::ocl_mem_ctl_t ctl,
  input  wire  [AW-1:0]              rd_addr,
  input  wire  [AW-1:0]              wr_addr,
  input  wire  [DW-1:0]              wr_data,
  output logic [DW-1:0]              rd_data
);

  // tag and key per entry, contents undefined until written
  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // single write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

[hdl/ocl_seq.sv]
`default_nettype none

module ocl_seq #(
  parameter int CAPACITY = 32,
  parameter int KW       = 32,
  parameter int AW       = 5,
  parameter int LW       = 6
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  input  wire ocl_pkg::ocl_in_t in_data,
  input  wire  [5:0]            cap_limit,
  output logic                  busy,
  output logic [LW-1:0]         len,
  output ocl_pkg::ocl_mem_ctl_t mem_ctl,
  output logic [AW-1:0]         rd_addr,
  output logic [AW-1:0]         wr_addr,
  output logic [KW:0]           wr_data,
  input  wire  [KW:0]           rd_data,
  output logic                  res_valid,
  input  wire                   res_ready,
  output ocl_pkg::ocl_out_t     res
);

  localparam int XW = (LW > 6) ? LW : 6;

  ocl_pkg::ocl_state_t state_r, state_nxt;

  logic [2:0]    cmd_r;
  logic [KW-1:0] key_r;
  logic          tag_r;
  logic [KW-1:0] tkey_r;
  logic [4:0]    pos_r;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic [LW-1:0] where_r, where_nxt;
  logic [1:0]    status_r, status_nxt;
  logic [KW-1:0] rkey_r, rkey_nxt;
  logic          rtag_r, rtag_nxt;

  logic          accept;
  logic          full;
  logic          empty;
  logic          pos_out;
  logic          hit;
  logic [KW-1:0] skey;
  logic [LW-1:0] idx_inc;
  logic [LW-1:0] idx_dec;
  logic [LW-1:0] mid;
  logic [LW-1:0] ins_where;

  assign accept  = in_valid && (state_r == ocl_pkg::S_IDLE);
  assign busy    = (state_r != ocl_pkg::S_IDLE);
  assign len     = len_r;

  // limit in force is the smaller of the register and the capacity
  assign full    = (XW'(len_r) >= XW'(cap_limit)) || (len_r == LW'(CAPACITY));
  assign empty   = (len_r == '0);
  assign pos_out = (XW'(pos_r) >= XW'(len_r));
  assign idx_inc = idx_r + LW'(1);
  assign idx_dec = idx_r - LW'(1);
  assign mid     = empty ? '0 : (((len_r - LW'(1)) >> 1) + LW'(1));

  // shared key comparator for both search commands
  assign skey = (cmd_r == ocl_pkg::CMD_AFTER) ? tkey_r : key_r;
  assign hit  = (rd_data[KW-1:0] == skey);

  always_comb begin
    case (cmd_r)
      ocl_pkg::CMD_MIDDLE: ins_where = mid;
      ocl_pkg::CMD_BACK:   ins_where = len_r;
      default:             ins_where = '0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ocl_pkg::S_IDLE;
      len_r   <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
    end
  end

  // command capture and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r  <= in_data.cmd;
      key_r  <= KW'(in_data.key);
      tag_r  <= in_data.tag;
      tkey_r <= KW'(in_data.target_key);
      pos_r  <= in_data.position;
    end
    idx_r    <= idx_nxt;
    where_r  <= where_nxt;
    status_r <= status_nxt;
    rkey_r   <= rkey_nxt;
    rtag_r   <= rtag_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ocl_pkg::S_IDLE: begin
        if (in_valid) state_nxt = ocl_pkg::S_DECODE;
      end
      ocl_pkg::S_DECODE: begin
        case (cmd_r)
          ocl_pkg::CMD_FRONT, ocl_pkg::CMD_MIDDLE, ocl_pkg::CMD_BACK: begin
            if (full)                   state_nxt = ocl_pkg::S_DONE;
            else if (len_r > ins_where) state_nxt = ocl_pkg::S_SHIFT_RD;
            else                        state_nxt = ocl_pkg::S_PLACE;
          end
          ocl_pkg::CMD_AFTER: begin
            if (full || empty) state_nxt = ocl_pkg::S_DONE;
            else               state_nxt = ocl_pkg::S_SRCH_RD;
          end
          ocl_pkg::CMD_REMOVE: begin
            if (empty) state_nxt = ocl_pkg::S_DONE;
            else       state_nxt = ocl_pkg::S_SRCH_RD;
          end
          ocl_pkg::CMD_READ: begin
            if (empty || pos_out) state_nxt = ocl_pkg::S_DONE;
            else                  state_nxt = ocl_pkg::S_RD_WAIT;
          end
          default: state_nxt = ocl_pkg::S_DONE;
        endcase
      end
      ocl_pkg::S_SRCH_RD: state_nxt = ocl_pkg::S_SRCH_CMP;
      ocl_pkg::S_SRCH_CMP: begin
        if (hit) begin
          if (cmd_r == ocl_pkg::CMD_AFTER) begin
            state_nxt = (len_r > idx_inc) ? ocl_pkg::S_SHIFT_RD : ocl_pkg::S_PLACE;
          end else begin
            state_nxt = (idx_inc < len_r) ? ocl_pkg::S_RM_RD : ocl_pkg::S_DONE;
          end
        end else begin
          state_nxt = (idx_inc >= len_r) ? ocl_pkg::S_DONE : ocl_pkg::S_SRCH_RD;
        end
      end
      ocl_pkg::S_SHIFT_RD: state_nxt = ocl_pkg::S_SHIFT_WR;
      ocl_pkg::S_SHIFT_WR: begin
        state_nxt = (idx_dec > where_r) ? ocl_pkg::S_SHIFT_RD : ocl_pkg::S_PLACE;
      end
      ocl_pkg::S_PLACE: state_nxt = ocl_pkg::S_DONE;
      ocl_pkg::S_RM_RD: state_nxt = ocl_pkg::S_RM_WR;
      ocl_pkg::S_RM_WR: begin
        state_nxt = ((idx_inc + LW'(1)) < len_r) ? ocl_pkg::S_RM_RD : ocl_pkg::S_DONE;
      end
      ocl_pkg::S_RD_WAIT: state_nxt = ocl_pkg::S_DONE;
      ocl_pkg::S_DONE: begin
        if (res_ready) state_nxt = ocl_pkg::S_IDLE;
      end
      default: state_nxt = ocl_pkg::S_IDLE;
    endcase
  end

  // datapath and store access per state
  always_comb begin
    len_nxt        = len_r;
    idx_nxt        = idx_r;
    where_nxt      = where_r;
    status_nxt     = status_r;
    rkey_nxt       = rkey_r;
    rtag_nxt       = rtag_r;
    mem_ctl.rd_en  = 1'b0;
    mem_ctl.wr_en  = 1'b0;
    rd_addr        = idx_r[AW-1:0];
    wr_addr        = idx_r[AW-1:0];
    wr_data        = rd_data;
    res_valid      = 1'b0;
    case (state_r)
      ocl_pkg::S_DECODE: begin
        status_nxt = ocl_pkg::STAT_OK;
        where_nxt  = '0;
        rkey_nxt   = '0;
        rtag_nxt   = 1'b0;
        idx_nxt    = '0;
        case (cmd_r)
          ocl_pkg::CMD_FRONT, ocl_pkg::CMD_MIDDLE, ocl_pkg::CMD_BACK: begin
            if (full) begin
              status_nxt = ocl_pkg::STAT_FULL;
            end else begin
              where_nxt = ins_where;
              idx_nxt   = len_r;
            end
          end
          ocl_pkg::CMD_AFTER: begin
            if (full)       status_nxt = ocl_pkg::STAT_FULL;
            else if (empty) status_nxt = ocl_pkg::STAT_EMPTY;
          end
          ocl_pkg::CMD_REMOVE: begin
            if (empty) status_nxt = ocl_pkg::STAT_EMPTY;
          end
          ocl_pkg::CMD_READ: begin
            if (empty) begin
              status_nxt = ocl_pkg::STAT_EMPTY;
            end else if (pos_out) begin
              status_nxt = ocl_pkg::STAT_MISSING;
            end else begin
              where_nxt     = LW'(pos_r);
              mem_ctl.rd_en = 1'b1;
              rd_addr       = AW'(pos_r);
            end
          end
          default: ;
        endcase
      end
      ocl_pkg::S_SRCH_RD: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = idx_r[AW-1:0];
      end
      ocl_pkg::S_SRCH_CMP: begin
        if (hit) begin
          if (cmd_r == ocl_pkg::CMD_AFTER) begin
            where_nxt = idx_inc;
            idx_nxt   = len_r;
          end else begin
            where_nxt = idx_r;
            // removing the last entry needs no shift
            if (!(idx_inc < len_r)) len_nxt = len_r - LW'(1);
          end
        end else begin
          idx_nxt = idx_inc;
          if (idx_inc >= len_r) status_nxt = ocl_pkg::STAT_MISSING;
        end
      end
      ocl_pkg::S_SHIFT_RD: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = idx_dec[AW-1:0];
      end
      ocl_pkg::S_SHIFT_WR: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = idx_r[AW-1:0];
        wr_data       = rd_data;
        idx_nxt       = idx_dec;
      end
      ocl_pkg::S_PLACE: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = where_r[AW-1:0];
        wr_data       = {tag_r, key_r};
        len_nxt       = len_r + LW'(1);
      end
      ocl_pkg::S_RM_RD: begin
        mem_ctl.rd_en = 1'b1;
        rd_addr       = idx_inc[AW-1:0];
      end
      ocl_pkg::S_RM_WR: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = idx_r[AW-1:0];
        wr_data       = rd_data;
        idx_nxt       = idx_inc;
        if (!((idx_inc + LW'(1)) < len_r)) len_nxt = len_r - LW'(1);
      end
      ocl_pkg::S_RD_WAIT: begin
        rkey_nxt = rd_data[KW-1:0];
        rtag_nxt = rd_data[KW];
      end
      ocl_pkg::S_DONE: begin
        res_valid = 1'b1;
      end
      default: ;
    endcase
  end

  // result fields
  always_comb begin
    res.status      = status_r;
    res.entry_count = 6'(len_r);
    res.where       = 5'(where_r);
    res.read_key    = 32'(rkey_r);
    res.read_tag    = rtag_r;
  end

endmodule

`default_nettype wire

[hdl/ordered_circular_list_engine_unit.sv]
`default_nettype none

// Ordered list engine: keeps up to CAPACITY (key, tag) entries in order from the
// head in a single-port-write, registered-read memory, and runs one command at a
// time under a small sequencer that reuses one key comparator and one index
// counter. A command is decoded first; a key search visits each entry with a
// read then a compare; each entry moved by an insert or remove is read, then
// written; placing the new entry is a step of its own; a read issues its
// access at decode and captures the data in a wait state; and the result is
// then loaded into the output register. The worst case is a search through
// every entry, or a search followed by a shift of the entries behind the match.
// in_stall stays high from the transfer of a command until its result has moved
// into the output register; the output register lets the next command start
// while that result still waits on out_stall. Writes to the capacity limit are
// always taken (cfg_ready is tied high) and apply from the next command on.
// The memory holds no reset state; entries are only read below the count.
module ordered_circular_list_engine_unit #(
  parameter int CAPACITY = 32,
  parameter int KEY_BITS = 32
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   in_valid,
  output logic                  in_stall,
  input  wire ocl_pkg::ocl_in_t in_data,
  output logic                  out_valid,
  input  wire                   out_stall,
  output ocl_pkg::ocl_out_t     out_data,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [5:0]            cfg_data
);

  localparam int KW = (KEY_BITS < 32) ? KEY_BITS : 32;
  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  logic [5:0]            cap_limit_r;
  logic                  out_valid_r;
  ocl_pkg::ocl_out_t     out_data_r;

  logic                  busy;
  logic [LW-1:0]         len;
  ocl_pkg::ocl_mem_ctl_t mem_ctl;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic [KW:0]           wr_data;
  logic [KW:0]           rd_data;
  logic                  res_valid;
  logic                  res_ready;
  ocl_pkg::ocl_out_t     res;

  // capacity limit register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_limit_r <= ocl_pkg::CAP_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_limit_r <= cfg_data;
    end
  end

  ocl_seq #(
    .CAPACITY (CAPACITY),
    .KW       (KW),
    .AW       (AW),
    .LW       (LW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cap_limit (cap_limit_r),
    .busy      (busy),
    .len       (len),
    .mem_ctl   (mem_ctl),
    .rd_addr   (rd_addr),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ocl_store #(
    .DEPTH (CAPACITY),
    .AW    (AW),
    .DW    (KW + 1)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  assign in_stall = busy;

  // output register, free when empty or being drained this cycle
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // list count never exceeds the storage depth
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len <= LW'(CAPACITY))
    else $error("entry count above capacity");

  // one command changes the count by at most one per cycle
  a_len_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((len == $past(len)) || (len == $past(len) + LW'(1)) ||
                      (len + LW'(1) == $past(len))))
    else $error("entry count jumped");

  // an idle block leaves the count alone
  a_idle_len: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |=> (len == $past(len)))
    else $error("entry count changed while idle");

  // a result is never loaded while the sequencer is idle
  a_res_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_ready) |=> (out_valid && !$past(in_valid && !in_stall)))
    else $error("result loaded without a command in flight");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int LIST_DEPTH = 32;
  localparam int CYCLE_LIMIT = 1000000;
  // command codes the block decodes as no-ops
  localparam logic [2:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0] CMD_UNUSED_HI = 3'd7;

  // ordered list predictor and queue of pending list results
  class list_scoreboard;
    logic [31:0]         keys [LIST_DEPTH];
    logic                tags [LIST_DEPTH];
    int                  count;
    int                  limit;
    ocl_pkg::ocl_out_t   expected_q [$];
    int unsigned         errors;
    int unsigned         accepted;
    int unsigned         checked;
    int unsigned         status_hits [4];

    function new();
      count = 0;
      limit = int'(ocl_pkg::CAP_LIMIT_RESET);
      errors = 0;
      accepted = 0;
      checked = 0;
      foreach (status_hits[i]) status_hits[i] = 0;
    endfunction

    function void set_limit(logic [5:0] v);
      limit = int'(v);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // any key currently held, or a random one for an empty list
    function logic [31:0] pick_present();
      if (count == 0) return $urandom;
      return keys[$urandom_range(count - 1)];
    endfunction

    function int find_key(logic [31:0] k);
      for (int i = 0; i < count; i++)
        if (keys[i] == k) return i;
      return -1;
    endfunction

    function void insert_at(int pos, logic [31:0] k, logic t);
      for (int i = count; i > pos; i--) begin
        keys[i] = keys[i - 1];
        tags[i] = tags[i - 1];
      end
      keys[pos] = k;
      tags[pos] = t;
      count++;
    endfunction

    function void remove_at(int pos);
      for (int i = pos; i + 1 < count; i++) begin
        keys[i] = keys[i + 1];
        tags[i] = tags[i + 1];
      end
      count--;
    endfunction

    // apply one accepted command and queue its result
    function void note_command(ocl_pkg::ocl_in_t c);
      ocl_pkg::ocl_out_t r;
      int hit;
      int cap;
      r = '0;
      cap = (limit < LIST_DEPTH) ? limit : LIST_DEPTH;
      accepted++;
      if (c.cmd <= ocl_pkg::CMD_AFTER && count >= cap) r.status = ocl_pkg::STAT_FULL;
      else case (c.cmd)
        ocl_pkg::CMD_FRONT: insert_at(0, c.key, c.tag);
        ocl_pkg::CMD_MIDDLE: begin
          r.where = 5'((count == 0) ? 0 : (count - 1) / 2 + 1);
          insert_at(int'(r.where), c.key, c.tag);
        end
        ocl_pkg::CMD_BACK: begin
          r.where = 5'(count);
          insert_at(count, c.key, c.tag);
        end
        ocl_pkg::CMD_AFTER: begin
          if (count == 0) r.status = ocl_pkg::STAT_EMPTY;
          else begin
            hit = find_key(c.target_key);
            if (hit < 0) r.status = ocl_pkg::STAT_MISSING;
            else begin
              r.where = 5'(hit + 1);
              insert_at(hit + 1, c.key, c.tag);
            end
          end
        end
        ocl_pkg::CMD_REMOVE: begin
          if (count == 0) r.status = ocl_pkg::STAT_EMPTY;
          else begin
            hit = find_key(c.key);
            if (hit < 0) r.status = ocl_pkg::STAT_MISSING;
            else begin
              r.where = 5'(hit);
              remove_at(hit);
            end
          end
        end
        ocl_pkg::CMD_READ: begin
          if (count == 0) r.status = ocl_pkg::STAT_EMPTY;
          else if (int'(c.position) >= count) r.status = ocl_pkg::STAT_MISSING;
          else begin
            r.where = c.position;
            r.read_key = keys[c.position];
            r.read_tag = tags[c.position];
          end
        end
        default: ;
      endcase
      r.entry_count = 6'(count);
      expected_q.push_back(r);
    endfunction

    function void report_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, got);
      end
    endfunction

    // compare one result transfer against the oldest prediction
    function void check_result(ocl_pkg::ocl_out_t got);
      ocl_pkg::ocl_out_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none actual %h", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      status_hits[exp_r.status]++;
      report_field("status", 32'(exp_r.status), 32'(got.status));
      report_field("entry_count", 32'(exp_r.entry_count), 32'(got.entry_count));
      report_field("where", 32'(exp_r.where), 32'(got.where));
      report_field("read_key", exp_r.read_key, got.read_key);
      report_field("read_tag", 32'(exp_r.read_tag), 32'(got.read_tag));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  ocl_pkg::ocl_in_t  in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  ocl_pkg::ocl_out_t out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [5:0]        cfg_data = '0;

  list_scoreboard board;
  int          in_idle_pct = 37;
  int          out_idle_pct = 59;
  logic        growing = 1'b1;
  logic [31:0] key_pool [12];
  int unsigned cycle_count = 0;

  ordered_circular_list_engine_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < out_idle_pct);
  end

  // result transfers
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  function automatic ocl_pkg::ocl_in_t mk(logic [2:0] op, logic [31:0] k, logic t,
                                          logic [31:0] tk, logic [4:0] p);
    ocl_pkg::ocl_in_t c;
    c.cmd = op;
    c.key = k;
    c.tag = t;
    c.target_key = tk;
    c.position = p;
    return c;
  endfunction

  // random command biased toward filling or draining the list
  function automatic ocl_pkg::ocl_in_t random_command();
    ocl_pkg::ocl_in_t c;
    int r;
    int cap;
    c.key = $urandom;
    c.tag = 1'($urandom_range(1));
    c.target_key = $urandom;
    c.position = 5'($urandom_range(31));
    cap = (board.limit < LIST_DEPTH) ? board.limit : LIST_DEPTH;
    if (board.count == 0) growing = 1'b1;
    else if (board.count >= cap && $urandom_range(5) == 0) growing = 1'b0;
    r = $urandom_range(99);
    if (r < 3) c.cmd = $urandom_range(1) ? CMD_UNUSED_HI : CMD_UNUSED_LO;
    else if (r < (growing ? 60 : 28))
      c.cmd = 3'($urandom_range(ocl_pkg::CMD_AFTER, ocl_pkg::CMD_FRONT));
    else if (r < (growing ? 78 : 50)) c.cmd = ocl_pkg::CMD_READ;
    else c.cmd = ocl_pkg::CMD_REMOVE;
    if (c.cmd == ocl_pkg::CMD_REMOVE && $urandom_range(99) < 70) c.key = board.pick_present();
    else if ($urandom_range(99) < 60) c.key = key_pool[$urandom_range(11)];
    if ($urandom_range(99) < 75) c.target_key = board.pick_present();
    else if ($urandom_range(99) < 50) c.target_key = key_pool[$urandom_range(11)];
    if ($urandom_range(99) < 80)
      c.position = 5'($urandom_range(board.count < 31 ? board.count : 31));
    return c;
  endfunction

  // one command transfer, with random sender gaps ahead of it
  task automatic send_command(input ocl_pkg::ocl_in_t c);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_command(c);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [5:0] v);
    settle_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_limit(v);
    cfg_valid <= 1'b0;
  endtask

  // corner cases at the reset limit
  task automatic run_directed();
    // empty list on every command that needs entries
    send_command(mk(ocl_pkg::CMD_READ, 32'h0, 1'b0, 32'h0, 5'd0));
    send_command(mk(ocl_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 1'b1, 32'h0, 5'd31));
    send_command(mk(ocl_pkg::CMD_AFTER, 32'h1, 1'b1, 32'hFFFF_FFFF, 5'd0));
    // middle into empty list, then every insert flavor
    send_command(mk(ocl_pkg::CMD_MIDDLE, 32'h0, 1'b0, 32'h0, 5'd0));
    send_command(mk(ocl_pkg::CMD_FRONT, 32'hFFFF_FFFF, 1'b1, 32'h0, 5'd31));
    send_command(mk(ocl_pkg::CMD_BACK, 32'h1234_5678, 1'b1, 32'hFFFF_FFFF, 5'd0));
    send_command(mk(ocl_pkg::CMD_MIDDLE, 32'hA5A5_A5A5, 1'b0, 32'h0, 5'd0));
    send_command(mk(ocl_pkg::CMD_MIDDLE, 32'h5A5A_5A5A, 1'b1, 32'h0, 5'd0));
    send_command(mk(ocl_pkg::CMD_AFTER, 32'hC3C3_C3C3, 1'b1, 32'hFFFF_FFFF, 5'd0));
    send_command(mk(ocl_pkg::CMD_AFTER, 32'h0F0F_0F0F, 1'b0, 32'h1234_5678, 5'd0));
    send_command(mk(ocl_pkg::CMD_AFTER, 32'h1, 1'b0, 32'hDEAD_BEEF, 5'd0));
    // duplicate key at the back
    send_command(mk(ocl_pkg::CMD_BACK, 32'h0, 1'b1, 32'h0, 5'd0));
    // reads at head, last, past the end and at the top position
    send_command(mk(ocl_pkg::CMD_READ, 32'h0, 1'b0, 32'h0, 5'd0));
    send_command(mk(ocl_pkg::CMD_READ, 32'h0, 1'b0, 32'h0, 5'd7));
    send_command(mk(ocl_pkg::CMD_READ, 32'h0, 1'b0, 32'h0, 5'd8));
    send_command(mk(ocl_pkg::CMD_READ, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 5'd31));
    // first match removal, head removal, missing key
    send_command(mk(ocl_pkg::CMD_REMOVE, 32'h0, 1'b0, 32'h0, 5'd0));
    send_command(mk(ocl_pkg::CMD_REMOVE, 32'hFFFF_FFFF, 1'b0, 32'h0, 5'd0));
    send_command(mk(ocl_pkg::CMD_READ, 32'h0, 1'b0, 32'h0, 5'd0));
    send_command(mk(ocl_pkg::CMD_REMOVE, 32'hDEAD_BEEF, 1'b0, 32'h0, 5'd0));
    // unused command codes
    send_command(mk(CMD_UNUSED_LO, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 5'd31));
    send_command(mk(CMD_UNUSED_HI, 32'h0, 1'b0, 32'h0, 5'd0));
    // removal of the entry just ahead of the tail
    send_command(mk(ocl_pkg::CMD_REMOVE, 32'h0F0F_0F0F, 1'b0, 32'h0, 5'd0));
    send_command(mk(ocl_pkg::CMD_READ, 32'h0, 1'b0, 32'h0, 5'd4));
  endtask

  task automatic run_phase(input logic [5:0] lim, input int n, input int in_pct,
                           input int out_pct);
    ocl_pkg::ocl_in_t c;
    int done;
    write_limit(lim);
    in_idle_pct = in_pct;
    out_idle_pct = out_pct;
    done = 0;
    while (done < n) begin
      c = random_command();
      send_command(c);
      if (c.cmd <= ocl_pkg::CMD_READ) done++;
    end
  endtask

  // main sequence
  initial begin
    board = new();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 12; i++) key_pool[i] = $urandom;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    // sender 37, receiver 59
    run_phase(6'd0, 40, 37, 59);
    run_phase(6'd1, 60, 37, 59);
    run_phase(6'd32, 500, 37, 59);
    // sender 59, receiver 37
    run_phase(6'd63, 300, 59, 37);
    run_phase(6'd2, 100, 59, 37);
    run_phase(6'($urandom_range(31, 3)), 300, 59, 37);
    // no idling
    run_phase(6'd20, 300, 0, 0);
    run_phase(6'($urandom_range(63)), 230, 0, 0);
    settle_idle();
    repeat (200) @(posedge clk);
    $display("ran %0d commands, checked %0d results, limits 0 to 63 under three pacing modes",
             board.accepted, board.checked);
    $display("results by status: ok %0d, full %0d, empty %0d, not found %0d",
             board.status_hits[ocl_pkg::STAT_OK], board.status_hits[ocl_pkg::STAT_FULL],
             board.status_hits[ocl_pkg::STAT_EMPTY], board.status_hits[ocl_pkg::STAT_MISSING]);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d errors, %0d results outstanding", board.errors, board.pending());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
